// ===== rtl/core/spdg_pkg.sv =====
// Shared types, constants and helper functions for the stereo pan and distance gain block.
`timescale 1ns / 1ps

package spdg_pkg;

  // CORDIC vectoring: number of micro-rotations, at most 24.
  localparam int CORDIC_STEPS = 16;
  localparam int CSTEP_W      = 5;
  localparam int CW           = 27;
  localparam logic signed [CW-1:0] ANG_PI = 27'sd16777216;

  // Serial multiplier: unsigned operands, two bits of the multiplier per cycle.
  localparam int MUL_W      = 32;
  localparam int MUL_DIGITS = MUL_W / 2;
  localparam int MUL_CNT_W  = $clog2(MUL_DIGITS);

  // Restoring divider: one quotient bit per cycle.
  localparam int DIV_W     = 32;
  localparam int DVS_W     = 25;
  localparam int DIV_CNT_W = $clog2(DIV_W);

  localparam int GAIN_W = 17;
  localparam int DIST_W = 25;
  localparam int PAN_W  = 17;

  localparam logic [MUL_W-1:0] INV_K    = 32'd652032874;
  localparam logic [15:0]      ATT_MIN  = 16'd3277;
  localparam logic [15:0]      Q15_ONE  = 16'd32768;
  localparam logic [DIV_W-1:0] ATT_NUM  = 32'h8000_0000;
  localparam logic [DVS_W-1:0] DEN_BASE = 25'd65536;
  localparam logic [DVS_W-1:0] DIST_DIV = 25'd10;

  localparam logic FUNC_LOCATION = 1'b0;
  localparam logic FUNC_SAMPLE   = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CORDIC,
    ST_DIST,
    ST_DIV10,
    ST_DIVATT,
    ST_BASE,
    ST_GAIN,
    ST_SMPG,
    ST_SMPV,
    ST_OUT
  } state_t;

  // Arctangent of 2^-i in units where 2^24 is pi.
  function automatic logic signed [CW-1:0] atan_lut(input logic [CSTEP_W-1:0] i);
    logic signed [CW-1:0] v;
    case (i)
      5'd0:    v = 27'sd4194304;
      5'd1:    v = 27'sd2476042;
      5'd2:    v = 27'sd1308273;
      5'd3:    v = 27'sd664100;
      5'd4:    v = 27'sd333339;
      5'd5:    v = 27'sd166832;
      5'd6:    v = 27'sd83436;
      5'd7:    v = 27'sd41721;
      5'd8:    v = 27'sd20861;
      5'd9:    v = 27'sd10430;
      5'd10:   v = 27'sd5215;
      5'd11:   v = 27'sd2608;
      5'd12:   v = 27'sd1304;
      5'd13:   v = 27'sd652;
      5'd14:   v = 27'sd326;
      5'd15:   v = 27'sd163;
      5'd16:   v = 27'sd81;
      5'd17:   v = 27'sd41;
      5'd18:   v = 27'sd20;
      5'd19:   v = 27'sd10;
      5'd20:   v = 27'sd5;
      5'd21:   v = 27'sd3;
      5'd22:   v = 27'sd1;
      5'd23:   v = 27'sd1;
      default: v = 27'sd0;
    endcase
    return v;
  endfunction

  // Applies a sign to a magnitude and saturates to a signed 16-bit value.
  function automatic logic [15:0] sat_mag(input logic neg, input logic [33:0] m);
    logic [15:0] r;
    if (!neg) begin
      r = (m > 34'd32767) ? 16'h7FFF : m[15:0];
    end else begin
      r = (m > 34'd32768) ? 16'h8000 : (16'd0 - m[15:0]);
    end
    return r;
  endfunction

  // Magnitude of a signed 16-bit value, 17 bits wide.
  function automatic logic [16:0] mag16(input logic [15:0] v);
    return v[15] ? (17'd0 - {1'b1, v}) : {1'b0, v};
  endfunction

  function automatic logic [15:0] clamp_q15(input logic [15:0] v);
    return (v > Q15_ONE) ? Q15_ONE : v;
  endfunction

endpackage

// ===== rtl/core/spdg_serial_mul.sv =====
// Radix-4 serial unsigned multiplier, two multiplier bits per cycle.
`timescale 1ns / 1ps

module spdg_serial_mul (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [spdg_pkg::MUL_W-1:0]    a,
  input  logic [spdg_pkg::MUL_W-1:0]    b,
  output logic [2*spdg_pkg::MUL_W-1:0]  prod,
  output logic                          done
);

  logic [spdg_pkg::MUL_W-1:0]     a_r;
  logic [spdg_pkg::MUL_W+1:0]     a3_r;
  logic [spdg_pkg::MUL_W+1:0]     pp;
  logic [spdg_pkg::MUL_W+1:0]     sum;
  logic [2*spdg_pkg::MUL_W-1:0]   prod_next;
  logic [spdg_pkg::MUL_CNT_W-1:0] cnt;
  logic                           busy;

  always_comb begin
    case (prod[1:0])
      2'd0:    pp = '0;
      2'd1:    pp = {2'b00, a_r};
      2'd2:    pp = {1'b0, a_r, 1'b0};
      2'd3:    pp = a3_r;
      default: pp = '0;
    endcase
    sum       = {2'b00, prod[2*spdg_pkg::MUL_W-1:spdg_pkg::MUL_W]} + pp;
    prod_next = {sum, prod[spdg_pkg::MUL_W-1:2]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == spdg_pkg::MUL_CNT_W'(spdg_pkg::MUL_DIGITS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r  <= a;
      a3_r <= {2'b00, a} + {1'b0, a, 1'b0};
      prod <= {{spdg_pkg::MUL_W{1'b0}}, b};
    end else if (busy) begin
      prod <= prod_next;
    end
  end

endmodule

// ===== rtl/core/spdg_serial_div.sv =====
// Restoring serial divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module spdg_serial_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [spdg_pkg::DIV_W-1:0]    dividend,
  input  logic [spdg_pkg::DVS_W-1:0]    divisor,
  output logic [spdg_pkg::DIV_W-1:0]    quotient,
  output logic                          done
);

  logic [spdg_pkg::DIV_W-1:0]     dq;
  logic [spdg_pkg::DVS_W-1:0]     dvs_r;
  logic [spdg_pkg::DVS_W-1:0]     rem;
  logic [spdg_pkg::DVS_W:0]       rem_sh;
  logic [spdg_pkg::DVS_W:0]       diff;
  logic                           ge;
  logic [spdg_pkg::DIV_CNT_W-1:0] cnt;
  logic                           busy;

  always_comb begin
    rem_sh = {rem, dq[spdg_pkg::DIV_W-1]};
    diff   = rem_sh - {1'b0, dvs_r};
    ge     = (rem_sh >= {1'b0, dvs_r});
  end

  assign quotient = dq;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == spdg_pkg::DIV_CNT_W'(spdg_pkg::DIV_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // The dividend shifts out of the top while quotient bits shift in below.
  always_ff @(posedge clk) begin
    if (start) begin
      dq    <= dividend;
      dvs_r <= divisor;
      rem   <= '0;
    end else if (busy) begin
      rem <= ge ? diff[spdg_pkg::DVS_W-1:0] : rem_sh[spdg_pkg::DVS_W-1:0];
      dq  <= {dq[spdg_pkg::DIV_W-2:0], ge};
    end
  end

endmodule

// ===== rtl/core/spdg_cordic.sv =====
// Iterative CORDIC in vectoring mode, one micro-rotation per cycle.
`timescale 1ns / 1ps

module spdg_cordic (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic signed [spdg_pkg::CW-1:0]    x_in,
  input  logic signed [spdg_pkg::CW-1:0]    y_in,
  output logic signed [spdg_pkg::CW-1:0]    x_out,
  output logic signed [spdg_pkg::CW-1:0]    z_out,
  output logic                              done
);

  logic signed [spdg_pkg::CW-1:0] x, y, z;
  logic signed [spdg_pkg::CW-1:0] xs, ys, ang;
  logic signed [spdg_pkg::CW-1:0] x_next, y_next, z_next;
  logic [spdg_pkg::CSTEP_W-1:0]   cnt;
  logic                           busy;

  always_comb begin
    xs  = x >>> cnt;
    ys  = y >>> cnt;
    ang = spdg_pkg::atan_lut(cnt);
    if (y[spdg_pkg::CW-1]) begin
      x_next = x - ys;
      y_next = y + xs;
      z_next = z - ang;
    end else begin
      x_next = x + ys;
      y_next = y - xs;
      z_next = z + ang;
    end
  end

  assign x_out = x;
  assign z_out = z;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == spdg_pkg::CSTEP_W'(spdg_pkg::CORDIC_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // A point in the left half-plane is turned by pi before the rotations.
  always_ff @(posedge clk) begin
    if (start) begin
      if (x_in[spdg_pkg::CW-1]) begin
        x <= -x_in;
        y <= -y_in;
        z <= y_in[spdg_pkg::CW-1] ? -spdg_pkg::ANG_PI : spdg_pkg::ANG_PI;
      end else begin
        x <= x_in;
        y <= y_in;
        z <= '0;
      end
    end else if (busy) begin
      x <= x_next;
      y <= y_next;
      z <= z_next;
    end
  end

endmodule

// ===== rtl/core/stereo_pan_distance_gain.sv =====
// Top level: pans a mono stream to stereo from a source location, with distance and volume gain.
//
//  Channel   Handshake              Payload
//  input     in_valid / in_stall    func, mono_sample, loc_x, loc_y, loc_confidence, end_of_block
//  output    out_valid / out_stall  left_sample, right_sample, last_of_block
//  config    cfg_valid / cfg_ready  volume
//
// A sample transaction runs two radix-4 multiplier passes of 16 digits each, then loads
// the output register once it is free and returns to idle; the left and right channels
// run side by side. A location transaction runs the CORDIC, three multiplier passes and
// two 32-bit divisions before returning to idle; the origin skips the CORDIC and the
// first multiply.
// Reset is synchronous: the gains go to zero (silent output) and the volume to 1.0.
// One transaction is worked on at a time; in_stall is high while it is in progress.
// A finished result waits in the output register while out_stall is high, and the
// next input transaction is accepted meanwhile.
`timescale 1ns / 1ps

module stereo_pan_distance_gain (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        func,
  input  logic [15:0] mono_sample,
  input  logic [15:0] loc_x,
  input  logic [15:0] loc_y,
  input  logic [15:0] loc_confidence,
  input  logic        end_of_block,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] left_sample,
  output logic [15:0] right_sample,
  output logic        last_of_block,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] volume
);

  spdg_pkg::state_t state, state_next;

  logic launched, launched_next;
  logic cstart, mstart, dstart;
  logic cdone, mdone_l, mdone_r, ddone;
  logic in_acc, out_load;

  // Operand and status registers.
  logic [15:0]                       vol_r;
  logic signed [spdg_pkg::CW-1:0]    x_r, y_r;
  logic [15:0]                       conf_r;
  logic [15:0]                       mono_r;
  logic                              eob_r;
  logic signed [spdg_pkg::PAN_W-1:0] pan;
  logic [spdg_pkg::DIST_W-1:0]       dist_q16;
  logic [21:0]                       q10;
  logic [15:0]                       att;
  logic [spdg_pkg::GAIN_W-1:0]       gain_l, gain_r;
  logic [15:0]                       smp_l, smp_r;
  logic [15:0]                       res_l, res_r;

  // Unit connections.
  logic signed [spdg_pkg::CW-1:0]      cx_out, cz_out;
  logic [spdg_pkg::MUL_W-1:0]          ma_l, mb_l, ma_r, mb_r;
  logic [2*spdg_pkg::MUL_W-1:0]        prod_l, prod_r;
  logic [spdg_pkg::DIV_W-1:0]          dvd, quo;
  logic [spdg_pkg::DVS_W-1:0]          dvs;

  // Derived values.
  logic signed [27:0]                  zp, zs;
  logic signed [spdg_pkg::PAN_W-1:0]   pan_c;
  logic signed [17:0]                  lb_full, rb_full;
  logic [16:0]                         lb, rb;
  logic [15:0]                         vol_eff;
  logic [15:0]                         att_q;

  assign in_acc    = in_valid && !in_stall;
  assign in_stall  = (state != spdg_pkg::ST_IDLE);
  assign cfg_ready = 1'b1;
  assign vol_eff   = spdg_pkg::clamp_q15(vol_r);

  // Pan from the CORDIC angle, rounded to Q1.15 and held within one.
  always_comb begin
    zp = {cz_out[spdg_pkg::CW-1], cz_out} + 28'sd256;
    zs = zp >>> 9;
    if (zs > 28'sd32768) begin
      pan_c = 17'sd32768;
    end else if (zs < -28'sd32768) begin
      pan_c = -17'sd32768;
    end else begin
      pan_c = zs[spdg_pkg::PAN_W-1:0];
    end
    lb_full = 18'sd65536 - {pan[spdg_pkg::PAN_W-1], pan};
    rb_full = 18'sd65536 + {pan[spdg_pkg::PAN_W-1], pan};
    lb      = lb_full[17:1];
    rb      = rb_full[17:1];
    att_q   = (quo[15:0] < spdg_pkg::ATT_MIN) ? spdg_pkg::ATT_MIN : quo[15:0];
  end

  // Operand selection for the shared arithmetic units.
  always_comb begin
    ma_l = '0;
    mb_l = '0;
    ma_r = '0;
    mb_r = '0;
    dvd  = {{(spdg_pkg::DIV_W - spdg_pkg::DIST_W){1'b0}}, dist_q16};
    dvs  = spdg_pkg::DIST_DIV;
    case (state)
      spdg_pkg::ST_DIST: begin
        ma_l = {{(spdg_pkg::MUL_W - spdg_pkg::CW){1'b0}}, x_r};
        mb_l = spdg_pkg::INV_K;
      end
      spdg_pkg::ST_DIVATT: begin
        dvd = spdg_pkg::ATT_NUM;
        dvs = spdg_pkg::DEN_BASE + {3'b000, q10};
      end
      spdg_pkg::ST_BASE: begin
        ma_l = {15'd0, lb};
        mb_l = {16'd0, att};
        ma_r = {15'd0, rb};
        mb_r = {16'd0, att};
      end
      spdg_pkg::ST_GAIN: begin
        ma_l = prod_l[spdg_pkg::MUL_W-1:0];
        mb_l = {16'd0, conf_r};
        ma_r = prod_r[spdg_pkg::MUL_W-1:0];
        mb_r = {16'd0, conf_r};
      end
      spdg_pkg::ST_SMPG: begin
        ma_l = {15'd0, spdg_pkg::mag16(mono_r)};
        mb_l = {15'd0, gain_l};
        ma_r = {15'd0, spdg_pkg::mag16(mono_r)};
        mb_r = {15'd0, gain_r};
      end
      spdg_pkg::ST_SMPV: begin
        ma_l = {15'd0, spdg_pkg::mag16(smp_l)};
        mb_l = {16'd0, vol_eff};
        ma_r = {15'd0, spdg_pkg::mag16(smp_r)};
        mb_r = {16'd0, vol_eff};
      end
      default: begin
        ma_l = '0;
      end
    endcase
  end

  // Sequencer: each working state starts its unit once and waits for it.
  always_comb begin
    state_next = state;
    cstart     = 1'b0;
    mstart     = 1'b0;
    dstart     = 1'b0;
    out_load   = 1'b0;
    case (state)
      spdg_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (func == spdg_pkg::FUNC_SAMPLE) begin
            state_next = spdg_pkg::ST_SMPG;
          end else if (loc_x == 16'd0 && loc_y == 16'd0) begin
            state_next = spdg_pkg::ST_DIV10;
          end else begin
            state_next = spdg_pkg::ST_CORDIC;
          end
        end
      end
      spdg_pkg::ST_CORDIC: begin
        cstart = !launched;
        if (cdone) begin
          state_next = spdg_pkg::ST_DIST;
        end
      end
      spdg_pkg::ST_DIST: begin
        mstart = !launched;
        if (mdone_l) begin
          state_next = spdg_pkg::ST_DIV10;
        end
      end
      spdg_pkg::ST_DIV10: begin
        dstart = !launched;
        if (ddone) begin
          state_next = spdg_pkg::ST_DIVATT;
        end
      end
      spdg_pkg::ST_DIVATT: begin
        dstart = !launched;
        if (ddone) begin
          state_next = spdg_pkg::ST_BASE;
        end
      end
      spdg_pkg::ST_BASE: begin
        mstart = !launched;
        if (mdone_l) begin
          state_next = spdg_pkg::ST_GAIN;
        end
      end
      spdg_pkg::ST_GAIN: begin
        mstart = !launched;
        if (mdone_l) begin
          state_next = spdg_pkg::ST_IDLE;
        end
      end
      spdg_pkg::ST_SMPG: begin
        mstart = !launched;
        if (mdone_l) begin
          state_next = spdg_pkg::ST_SMPV;
        end
      end
      spdg_pkg::ST_SMPV: begin
        mstart = !launched;
        if (mdone_l) begin
          state_next = spdg_pkg::ST_OUT;
        end
      end
      spdg_pkg::ST_OUT: begin
        if (!out_valid || !out_stall) begin
          out_load   = 1'b1;
          state_next = spdg_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = spdg_pkg::ST_IDLE;
      end
    endcase
    launched_next = (state_next == state) ? (launched || cstart || mstart || dstart) : 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= spdg_pkg::ST_IDLE;
      launched  <= 1'b0;
      out_valid <= 1'b0;
      vol_r     <= spdg_pkg::Q15_ONE;
      gain_l    <= '0;
      gain_r    <= '0;
    end else begin
      state    <= state_next;
      launched <= launched_next;
      if (cfg_valid && cfg_ready) begin
        vol_r <= volume;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (state == spdg_pkg::ST_GAIN && mdone_l) begin
        gain_l <= prod_l[46:30];
        gain_r <= prod_r[46:30];
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      x_r      <= {{3{loc_x[15]}}, loc_x, 8'd0};
      y_r      <= {{3{loc_y[15]}}, loc_y, 8'd0};
      conf_r   <= spdg_pkg::clamp_q15(loc_confidence);
      mono_r   <= mono_sample;
      eob_r    <= end_of_block;
      pan      <= '0;
      dist_q16 <= '0;
    end
    if (state == spdg_pkg::ST_CORDIC && cdone) begin
      pan <= pan_c;
      x_r <= cx_out;
    end
    if (state == spdg_pkg::ST_DIST && mdone_l) begin
      dist_q16 <= prod_l[54:30];
    end
    if (state == spdg_pkg::ST_DIV10 && ddone) begin
      q10 <= quo[21:0];
    end
    if (state == spdg_pkg::ST_DIVATT && ddone) begin
      att <= att_q;
    end
    if (state == spdg_pkg::ST_SMPG && mdone_l) begin
      smp_l <= spdg_pkg::sat_mag(mono_r[15], prod_l[48:15]);
      smp_r <= spdg_pkg::sat_mag(mono_r[15], prod_r[48:15]);
    end
    if (state == spdg_pkg::ST_SMPV && mdone_l) begin
      res_l <= spdg_pkg::sat_mag(smp_l[15], prod_l[48:15]);
      res_r <= spdg_pkg::sat_mag(smp_r[15], prod_r[48:15]);
    end
    if (out_load) begin
      left_sample   <= res_l;
      right_sample  <= res_r;
      last_of_block <= eob_r;
    end
  end

  spdg_cordic u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (cstart),
    .x_in  (x_r),
    .y_in  (y_r),
    .x_out (cx_out),
    .z_out (cz_out),
    .done  (cdone)
  );

  spdg_serial_mul u_mul_l (
    .clk   (clk),
    .rst   (rst),
    .start (mstart),
    .a     (ma_l),
    .b     (mb_l),
    .prod  (prod_l),
    .done  (mdone_l)
  );

  spdg_serial_mul u_mul_r (
    .clk   (clk),
    .rst   (rst),
    .start (mstart),
    .a     (ma_r),
    .b     (mb_r),
    .prod  (prod_r),
    .done  (mdone_r)
  );

  spdg_serial_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (dstart),
    .dividend (dvd),
    .divisor  (dvs),
    .quotient (quo),
    .done     (ddone)
  );

  // A location transaction never produces a result.
  a_loc_no_result: assert property (@(posedge clk) disable iff (rst)
    (in_acc && func == spdg_pkg::FUNC_LOCATION) |=> !$rose(out_valid))
    else $error("result raised after a location transaction");

  // The two multipliers are started together and so finish together.
  a_mul_lockstep: assert property (@(posedge clk) disable iff (rst)
    mdone_l == mdone_r)
    else $error("left and right multipliers out of step");

  // The gains never exceed one and a half in Q2.15.
  a_gain_range: assert property (@(posedge clk) disable iff (rst)
    gain_l <= 17'd49152 && gain_r <= 17'd49152)
    else $error("gain out of range");

  // Only one arithmetic unit is started at a time.
  a_one_start: assert property (@(posedge clk) disable iff (rst)
    $countones({cstart, mstart, dstart}) <= 1)
    else $error("more than one unit started");

endmodule

// ===== test/tb.sv =====
// Self-checking testbench for the stereo pan and distance gain block.
`timescale 1ns / 1ps

module tb;

  // One input transaction as the driver presents it.
  typedef struct {
    logic        func;
    logic [15:0] mono;
    logic [15:0] lx;
    logic [15:0] ly;
    logic [15:0] conf;
    logic        eob;
  } pan_item_t;

  // One stereo result as it should leave the block.
  typedef struct {
    logic [15:0] left;
    logic [15:0] right;
    logic        last;
  } stereo_out_t;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int SETTLE_CYCLES  = 400;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        func = 1'b0;
  logic [15:0] mono_sample = '0;
  logic [15:0] loc_x = '0;
  logic [15:0] loc_y = '0;
  logic [15:0] loc_confidence = '0;
  logic        end_of_block = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [15:0] left_sample;
  logic [15:0] right_sample;
  logic        last_of_block;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] volume = '0;

  pan_item_t   pending_items[$];
  stereo_out_t expected_stereo[$];

  // The predictor's own copy of the block's state.
  logic [15:0]     vol_reg = spdg_pkg::Q15_ONE;
  logic [spdg_pkg::GAIN_W-1:0] gain_l_model = '0;
  logic [spdg_pkg::GAIN_W-1:0] gain_r_model = '0;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int error_count   = 0;
  int loc_count     = 0;
  int sample_count  = 0;
  int result_count  = 0;
  int quiet_cycles  = 0;

  stereo_pan_distance_gain dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .func(func), .mono_sample(mono_sample), .loc_x(loc_x), .loc_y(loc_y),
    .loc_confidence(loc_confidence), .end_of_block(end_of_block),
    .out_valid(out_valid), .out_stall(out_stall),
    .left_sample(left_sample), .right_sample(right_sample),
    .last_of_block(last_of_block),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .volume(volume)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic longint arctan_step(input int i);
    case (i)
      0: return 4194304;  1: return 2476042;  2: return 1308273;  3: return 664100;
      4: return 333339;   5: return 166832;   6: return 83436;    7: return 41721;
      8: return 20861;    9: return 10430;    10: return 5215;    11: return 2608;
      12: return 1304;    13: return 652;     14: return 326;     15: return 163;
      16: return 81;      17: return 41;      18: return 20;      19: return 10;
      20: return 5;       21: return 3;       default: return 1;
    endcase
  endfunction

  function automatic logic [15:0] sat_to_16(input longint v);
    if (v > 32767) return 16'h7FFF;
    if (v < -32768) return 16'h8000;
    return v[15:0];
  endfunction

  // Works out the new left and right gains from a location transaction.
  task automatic update_gains(input logic [15:0] lx, input logic [15:0] ly,
                              input logic [15:0] conf_in);
    longint x, y, z, xs, ys, pan, att, lb, rb, conf;
    longint unsigned dist_q16, den;
    x = longint'($signed(lx)) * 256;
    y = longint'($signed(ly)) * 256;
    z = 0;
    pan = 0;
    dist_q16 = 0;
    conf = (conf_in > spdg_pkg::Q15_ONE) ? 32768 : longint'(conf_in);
    if (x != 0 || y != 0) begin
      // Left half-plane: mirror through the origin and start from +/- pi.
      if (x < 0) begin
        z = (y >= 0) ? 16777216 : -16777216;
        x = -x;
        y = -y;
      end
      for (int i = 0; i < spdg_pkg::CORDIC_STEPS && i < 24; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (y < 0) begin
          x = x - ys;
          y = y + xs;
          z = z - arctan_step(i);
        end else begin
          x = x + ys;
          y = y - xs;
          z = z + arctan_step(i);
        end
      end
      pan = (z + 256) >>> 9;
      if (pan > 32768) pan = 32768;
      if (pan < -32768) pan = -32768;
      dist_q16 = (longint'(x) * 64'd652032874) >> 30;
    end
    den = 65536 + dist_q16 / 10;
    att = longint'((64'd1 << 31) / den);
    if (att < 3277) att = 3277;
    lb = (65536 - pan) >>> 1;
    rb = (65536 + pan) >>> 1;
    gain_l_model = spdg_pkg::GAIN_W'(((lb * att * conf) >> 30) & 64'h1FFFF);
    gain_r_model = spdg_pkg::GAIN_W'(((rb * att * conf) >> 30) & 64'h1FFFF);
  endtask

  function automatic logic [15:0] scale_channel(input logic [15:0] s,
                                               input logic [spdg_pkg::GAIN_W-1:0] g,
                                               input logic [15:0] v);
    longint a;
    a = longint'($signed(sat_to_16((longint'($signed(s)) * longint'(g)) / 32768)));
    return sat_to_16((a * longint'(v)) / 32768);
  endfunction

  // Driver: presents queued transactions and runs the predictor on acceptance.
  always @(posedge clk) begin
    pan_item_t it;
    stereo_out_t r;
    logic [15:0] v;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        if (func == spdg_pkg::FUNC_LOCATION) begin
          update_gains(loc_x, loc_y, loc_confidence);
          loc_count++;
        end else begin
          v = (vol_reg > spdg_pkg::Q15_ONE) ? spdg_pkg::Q15_ONE : vol_reg;
          r.left  = scale_channel(mono_sample, gain_l_model, v);
          r.right = scale_channel(mono_sample, gain_r_model, v);
          r.last  = end_of_block;
          expected_stereo.push_back(r);
          sample_count++;
        end
      end
      if (!(in_valid && in_stall)) begin
        if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          it = pending_items.pop_front();
          in_valid       <= 1'b1;
          func           <= it.func;
          mono_sample    <= it.mono;
          loc_x          <= it.lx;
          loc_y          <= it.ly;
          loc_confidence <= it.conf;
          end_of_block   <= it.eob;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: applies back-pressure and checks each result against the oldest expectation.
  always @(posedge clk) begin
    stereo_out_t e;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        result_count++;
        if (expected_stereo.size() == 0) begin
          $display("%0t: result with nothing expected: L=%h R=%h last=%b",
                   $time, left_sample, right_sample, last_of_block);
          error_count++;
        end else begin
          e = expected_stereo.pop_front();
          if (left_sample !== e.left) begin
            $display("%0t: left_sample expected %h actual %h", $time, e.left, left_sample);
            error_count++;
          end
          if (right_sample !== e.right) begin
            $display("%0t: right_sample expected %h actual %h", $time, e.right, right_sample);
            error_count++;
          end
          if (last_of_block !== e.last) begin
            $display("%0t: last_of_block expected %b actual %b", $time, e.last, last_of_block);
            error_count++;
          end
        end
      end
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Watchdog: ends the run when nothing has moved for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog expired, %0d results outstanding", $time,
               expected_stereo.size());
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic write_volume(input logic [15:0] v);
    @(posedge clk);
    cfg_valid <= 1'b1;
    volume    <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    vol_reg = v;
  endtask

  task automatic queue_item(input logic f, input logic [15:0] m, input logic [15:0] x,
                            input logic [15:0] y, input logic [15:0] c, input logic e);
    pan_item_t it;
    it.func = f; it.mono = m; it.lx = x; it.ly = y; it.conf = c; it.eob = e;
    pending_items.push_back(it);
  endtask

  // Waits for every result, then lets any location computation finish.
  task automatic drain;
    while (pending_items.size() > 0 || expected_stereo.size() > 0 || in_valid)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Mostly sample runs under a fresh location, with the odd stray location in between.
  task automatic queue_random(input int n);
    int run;
    for (int k = 0; k < n; k += run + 1) begin
      queue_item(spdg_pkg::FUNC_LOCATION, 16'($urandom), 16'($urandom), 16'($urandom),
                 ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(32768)),
                 1'($urandom));
      run = $urandom_range(12);
      for (int j = 0; j < run; j++)
        queue_item(spdg_pkg::FUNC_SAMPLE, 16'($urandom), 16'($urandom), 16'($urandom),
                   16'($urandom), (j == run - 1) || ($urandom_range(7) == 0));
    end
  endtask

  initial begin
    logic [15:0] vols[6];
    vols = '{16'd16384, 16'd0, 16'hFFFF, 16'd32769, 16'($urandom), 16'd32768};
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    send_idle_pct = 17;
    recv_idle_pct = 54;

    // Silent before any location, then the origin and the extremes of position.
    queue_item(spdg_pkg::FUNC_SAMPLE, 16'h7FFF, 16'h1234, 16'h4321, 16'hFFFF, 1'b0);
    queue_item(spdg_pkg::FUNC_SAMPLE, 16'h8000, 16'h0, 16'h0, 16'h0, 1'b1);
    queue_item(spdg_pkg::FUNC_LOCATION, 16'h7FFF, 16'h0, 16'h0, 16'd32768, 1'b1);
    queue_item(spdg_pkg::FUNC_SAMPLE, 16'h7FFF, 16'h0, 16'h0, 16'h0, 1'b0);
    queue_item(spdg_pkg::FUNC_SAMPLE, 16'h8000, 16'h0, 16'h0, 16'h0, 1'b1);
    // Source straight behind: the pan sits against its clamp.
    queue_item(spdg_pkg::FUNC_LOCATION, 16'h0, 16'h8000, 16'h0000, 16'hFFFF, 1'b0);
    queue_item(spdg_pkg::FUNC_SAMPLE, 16'h8000, 16'h0, 16'h0, 16'h0, 1'b0);
    queue_item(spdg_pkg::FUNC_LOCATION, 16'h0, 16'h8000, 16'hFFFF, 16'd32768, 1'b0);
    queue_item(spdg_pkg::FUNC_SAMPLE, 16'h7FFF, 16'h0, 16'h0, 16'h0, 1'b1);
    queue_item(spdg_pkg::FUNC_LOCATION, 16'h0, 16'h7FFF, 16'h7FFF, 16'd32768, 1'b0);
    queue_item(spdg_pkg::FUNC_SAMPLE, 16'h8000, 16'h0, 16'h0, 16'h0, 1'b0);
    queue_item(spdg_pkg::FUNC_LOCATION, 16'h0, 16'h8000, 16'h8000, 16'd32768, 1'b0);
    queue_item(spdg_pkg::FUNC_SAMPLE, 16'h7FFF, 16'h0, 16'h0, 16'h0, 1'b0);
    queue_item(spdg_pkg::FUNC_LOCATION, 16'h0, 16'h0, 16'h7FFF, 16'd32768, 1'b0);
    queue_item(spdg_pkg::FUNC_SAMPLE, 16'h0001, 16'h0, 16'h0, 16'h0, 1'b0);
    queue_item(spdg_pkg::FUNC_LOCATION, 16'h0, 16'h0100, 16'h0, 16'd0, 1'b0);
    queue_item(spdg_pkg::FUNC_SAMPLE, 16'h7FFF, 16'h0, 16'h0, 16'h0, 1'b1);
    queue_item(spdg_pkg::FUNC_LOCATION, 16'h0, 16'h0001, 16'hFFFF, 16'd32767, 1'b0);
    queue_item(spdg_pkg::FUNC_SAMPLE, 16'hFFFF, 16'h0, 16'h0, 16'h0, 1'b0);
    queue_item(spdg_pkg::FUNC_SAMPLE, 16'h8000, 16'h0, 16'h0, 16'h0, 1'b1);
    drain();

    for (int p = 0; p < 6; p++) begin
      if (p == 2) begin
        send_idle_pct = 54;
        recv_idle_pct = 17;
      end else if (p == 4) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      write_volume(vols[p]);
      queue_random(310);
      drain();
    end

    $display("Covered %0d location and %0d sample transactions, %0d results checked,",
             loc_count, sample_count, result_count);
    $display("over six volume settings and three back-pressure patterns.");
    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
